// ===== hw/rtl/obpc_pkg.sv =====
package obpc_pkg;

   // field widths
   localparam int COORD_W    = 21;
   localparam int NORMAL_W   = 16;
   localparam int AXIS_W     = 16;
   localparam int CEN_W      = COORD_W + 1;
   localparam int POS_PROD_W = CEN_W + AXIS_W;
   localparam int NRM_PROD_W = NORMAL_W + AXIS_W;

   // register widths
   localparam int BOX_W = 3 * COORD_W;
   localparam int ROW_W = 3 * AXIS_W;
   localparam int TOL_W = 20;
   localparam int COS_W = 15;

   localparam int AXIS_FRAC_BITS_DEF = 14;
   localparam logic [COS_W-1:0] COS_LIMIT_RESET = 15'd16384;

   // register file port
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_LSB    = 3;

   typedef enum logic [2:0] {
      REG_BOX_CENTER      = 3'd0,
      REG_BOX_SIZE        = 3'd1,
      REG_AXIS_ROW_ZERO   = 3'd2,
      REG_AXIS_ROW_ONE    = 3'd3,
      REG_AXIS_ROW_TWO    = 3'd4,
      REG_INNER_TOLERANCE = 3'd5,
      REG_OUTER_TOLERANCE = 3'd6,
      REG_COSINE_LIMIT    = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      CLASS_INLIER    = 2'd0,
      CLASS_OUTLIER   = 2'd1,
      CLASS_CONTAINED = 2'd2
   } point_class_type;

   typedef struct packed {
      logic [BOX_W-1:0]          box_center;
      logic [BOX_W-1:0]          box_size;
      logic [2:0][ROW_W-1:0]     axis_row;
      logic [TOL_W-1:0]          inner_tol;
      logic [TOL_W-1:0]          outer_tol;
      logic [COS_W-1:0]          cos_limit;
   } cfg_type;

   // products indexed [axis row][component]
   typedef struct packed {
      logic [2:0][2:0][POS_PROD_W-1:0] pos;
      logic [2:0][2:0][NRM_PROD_W-1:0] nrm;
   } prod_type;

endpackage

// ===== hw/rtl/oriented_box_point_classifier_core.sv =====
// a beat passes the input register, product register and result register before it shows on rsp_valid
// throughput: one beat per cycle unless rsp_ready stalls, set by the three-stage pipeline of input
//   register, product register (eighteen multipliers in parallel) and result register
// a stall on rsp_ready backs up stage by stage; empty stages still take beats
// reset: synchronous, clears all valid bits and loads the register file defaults
module oriented_box_point_classifier_core #(
   parameter int AXIS_FRAC_BITS = obpc_pkg::AXIS_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [obpc_pkg::COORD_W-1:0]  req_point_x,
   input  logic signed [obpc_pkg::COORD_W-1:0]  req_point_y,
   input  logic signed [obpc_pkg::COORD_W-1:0]  req_point_z,
   input  logic signed [obpc_pkg::NORMAL_W-1:0] req_normal_x,
   input  logic signed [obpc_pkg::NORMAL_W-1:0] req_normal_y,
   input  logic signed [obpc_pkg::NORMAL_W-1:0] req_normal_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_point_class,
   output logic                                rsp_normal_aligned,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [obpc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [obpc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [obpc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import obpc_pkg::*;

   cfg_type                    cfg;
   prod_type                   prod;
   point_class_type            cls;
   logic                       aligned;

   logic signed [COORD_W-1:0]  pt_x_ff;
   logic signed [COORD_W-1:0]  pt_y_ff;
   logic signed [COORD_W-1:0]  pt_z_ff;
   logic signed [NORMAL_W-1:0] nrm_x_ff;
   logic signed [NORMAL_W-1:0] nrm_y_ff;
   logic signed [NORMAL_W-1:0] nrm_z_ff;
   point_class_type            rsp_class_ff;
   logic                       rsp_aligned_ff;

   logic s0_valid_ff, s0_valid_in;
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_adv, s1_en, s0_en;

   // a stage moves when it is empty or the stage after it moves
   assign rsp_adv   = !rsp_valid_ff || rsp_ready;
   assign s1_en     = !s1_valid_ff || rsp_adv;
   assign s0_en     = !s0_valid_ff || s1_en;
   assign req_ready = s0_en;

   assign s0_valid_in  = s0_en   ? req_valid   : s0_valid_ff;
   assign s1_valid_in  = s1_en   ? s0_valid_ff : s1_valid_ff;
   assign rsp_valid_in = rsp_adv ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_en && req_valid) begin
         pt_x_ff  <= req_point_x;
         pt_y_ff  <= req_point_y;
         pt_z_ff  <= req_point_z;
         nrm_x_ff <= req_normal_x;
         nrm_y_ff <= req_normal_y;
         nrm_z_ff <= req_normal_z;
      end
      if (rsp_adv && s1_valid_ff) begin
         rsp_class_ff   <= cls;
         rsp_aligned_ff <= aligned;
      end
   end

   obpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   obpc_mult_stage u_mult (
      .clock    (clock),
      .load     (s1_en && s0_valid_ff),
      .point_x  (pt_x_ff),
      .point_y  (pt_y_ff),
      .point_z  (pt_z_ff),
      .normal_x (nrm_x_ff),
      .normal_y (nrm_y_ff),
      .normal_z (nrm_z_ff),
      .cfg      (cfg),
      .prod     (prod)
   );

   obpc_class_stage #(
      .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
   ) u_class (
      .prod           (prod),
      .cfg            (cfg),
      .point_class    (cls),
      .normal_aligned (aligned)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_point_class    = rsp_class_ff;
   assign rsp_normal_aligned = rsp_aligned_ff;

   // alignment is only reported for surface points
   a_aligned_inlier: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_normal_aligned |-> rsp_point_class == CLASS_INLIER)
      else $error("aligned flag on a non-inlier beat");

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s0_valid_ff)
      else $error("accepted beat missing from input stage");

   a_s1_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_en |=> s1_valid_ff)
      else $error("product stage dropped a stalled beat");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !s0_valid_ff && !s1_valid_ff |-> req_ready)
      else $error("empty pipeline refuses a beat");

endmodule

// ===== hw/rtl/obpc_csr.sv =====
module obpc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [obpc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [obpc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [obpc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output obpc_pkg::cfg_type                 cfg
);
   import obpc_pkg::*;

   cfg_type       cfg_ff;
   reg_index_type reg_index;
   logic          write_en;

   assign pready    = 1'b1;
   assign reg_index = reg_index_type'(paddr[CSR_ADDR_W-1:CSR_LSB]);
   assign write_en  = psel && penable && pwrite && pready;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{box_center: '0, box_size: '0, axis_row: '0, inner_tol: '0,
                     outer_tol: '0, cos_limit: COS_LIMIT_RESET};
      end else if (write_en) begin
         case (reg_index)
            REG_BOX_CENTER:      cfg_ff.box_center  <= pwdata[BOX_W-1:0];
            REG_BOX_SIZE:        cfg_ff.box_size    <= pwdata[BOX_W-1:0];
            REG_AXIS_ROW_ZERO:   cfg_ff.axis_row[0] <= pwdata[ROW_W-1:0];
            REG_AXIS_ROW_ONE:    cfg_ff.axis_row[1] <= pwdata[ROW_W-1:0];
            REG_AXIS_ROW_TWO:    cfg_ff.axis_row[2] <= pwdata[ROW_W-1:0];
            REG_INNER_TOLERANCE: cfg_ff.inner_tol   <= pwdata[TOL_W-1:0];
            REG_OUTER_TOLERANCE: cfg_ff.outer_tol   <= pwdata[TOL_W-1:0];
            REG_COSINE_LIMIT:    cfg_ff.cos_limit   <= pwdata[COS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_BOX_CENTER:      prdata = CSR_DATA_W'(cfg_ff.box_center);
         REG_BOX_SIZE:        prdata = CSR_DATA_W'(cfg_ff.box_size);
         REG_AXIS_ROW_ZERO:   prdata = CSR_DATA_W'(cfg_ff.axis_row[0]);
         REG_AXIS_ROW_ONE:    prdata = CSR_DATA_W'(cfg_ff.axis_row[1]);
         REG_AXIS_ROW_TWO:    prdata = CSR_DATA_W'(cfg_ff.axis_row[2]);
         REG_INNER_TOLERANCE: prdata = CSR_DATA_W'(cfg_ff.inner_tol);
         REG_OUTER_TOLERANCE: prdata = CSR_DATA_W'(cfg_ff.outer_tol);
         REG_COSINE_LIMIT:    prdata = CSR_DATA_W'(cfg_ff.cos_limit);
         default:             prdata = '0;
      endcase
   end

endmodule

// ===== hw/rtl/obpc_mult_stage.sv =====
module obpc_mult_stage (
   input  logic                                clock,
   input  logic                                load,
   input  logic signed [obpc_pkg::COORD_W-1:0]  point_x,
   input  logic signed [obpc_pkg::COORD_W-1:0]  point_y,
   input  logic signed [obpc_pkg::COORD_W-1:0]  point_z,
   input  logic signed [obpc_pkg::NORMAL_W-1:0] normal_x,
   input  logic signed [obpc_pkg::NORMAL_W-1:0] normal_y,
   input  logic signed [obpc_pkg::NORMAL_W-1:0] normal_z,
   input  obpc_pkg::cfg_type                    cfg,
   output obpc_pkg::prod_type                   prod
);
   import obpc_pkg::*;

   logic signed [COORD_W-1:0]    pt  [3];
   logic signed [COORD_W-1:0]    ctr [3];
   logic signed [CEN_W-1:0]      cen [3];
   logic signed [NORMAL_W-1:0]   nrm [3];
   logic signed [AXIS_W-1:0]     ax;
   logic signed [POS_PROD_W-1:0] pp;
   logic signed [NRM_PROD_W-1:0] np;
   prod_type                     prod_in;
   prod_type                     prod_ff;

   always_comb begin
      pt[0]  = point_x;
      pt[1]  = point_y;
      pt[2]  = point_z;
      nrm[0] = normal_x;
      nrm[1] = normal_y;
      nrm[2] = normal_z;
      for (int k = 0; k < 3; k++) begin
         ctr[k] = cfg.box_center[COORD_W*k +: COORD_W];
         cen[k] = pt[k] - ctr[k];
      end
      prod_in = '0;
      ax      = '0;
      pp      = '0;
      np      = '0;
      // nine position and nine normal products, all in parallel
      for (int d = 0; d < 3; d++) begin
         for (int k = 0; k < 3; k++) begin
            ax                = cfg.axis_row[d][AXIS_W*k +: AXIS_W];
            pp                = cen[k] * ax;
            np                = nrm[k] * ax;
            prod_in.pos[d][k] = pp;
            prod_in.nrm[d][k] = np;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

// ===== hw/rtl/obpc_class_stage.sv =====
module obpc_class_stage #(
   parameter int AXIS_FRAC_BITS = obpc_pkg::AXIS_FRAC_BITS_DEF
) (
   input  obpc_pkg::prod_type         prod,
   input  obpc_pkg::cfg_type          cfg,
   output obpc_pkg::point_class_type  point_class,
   output logic                       normal_aligned
);
   import obpc_pkg::*;

   localparam int CMP_MIN = POS_PROD_W + 4;
   localparam int CMP_REQ = COORD_W + AXIS_FRAC_BITS + 3;
   localparam int CMP_W   = (CMP_REQ > CMP_MIN) ? CMP_REQ : CMP_MIN;
   localparam int DOT_MIN = NRM_PROD_W + 2;
   localparam int DOT_A   = 2 * AXIS_FRAC_BITS + 2;
   localparam int DOT_B   = COS_W + AXIS_FRAC_BITS + 1;
   localparam int DOT_AB  = (DOT_A > DOT_B) ? DOT_A : DOT_B;
   localparam int DOT_W   = (DOT_AB > DOT_MIN) ? DOT_AB : DOT_MIN;
   localparam logic [DOT_W-1:0] DOT_ONE = DOT_W'(1) << (2 * AXIS_FRAC_BITS);

   logic signed [CMP_W-1:0] proj;
   logic [CMP_W-1:0]        dist2;
   logic [CMP_W-1:0]        half2;
   logic [CMP_W-1:0]        tin;
   logic [CMP_W-1:0]        tout;
   logic [CMP_W-1:0]        diff;
   logic signed [DOT_W-1:0] dsum;
   logic [DOT_W-1:0]        dmag;
   logic [DOT_W-1:0]        lim;
   logic                    done;
   logic                    hit;
   point_class_type         cls;

   always_comb begin
      tin  = CMP_W'(cfg.inner_tol) << (AXIS_FRAC_BITS + 1);
      tout = CMP_W'(cfg.outer_tol) << (AXIS_FRAC_BITS + 1);
      cls  = CLASS_CONTAINED;
      done = 1'b0;
      for (int d = 0; d < 3; d++) begin
         proj  = $signed(prod.pos[d][0]) + $signed(prod.pos[d][1])
               + $signed(prod.pos[d][2]);
         dist2 = (proj[CMP_W-1] ? CMP_W'(-proj) : CMP_W'(proj)) << 1;
         half2 = CMP_W'(cfg.box_size[COORD_W*d +: COORD_W]) << AXIS_FRAC_BITS;
         diff  = (dist2 >= half2) ? dist2 - half2 : half2 - dist2;
         // first axis that decides wins
         if (!done) begin
            if (dist2 > half2 + tout) begin
               cls  = CLASS_OUTLIER;
               done = 1'b1;
            end else if (diff <= tin) begin
               cls  = CLASS_INLIER;
               done = 1'b1;
            end
         end
      end
   end

   always_comb begin
      lim = DOT_W'(cfg.cos_limit) << AXIS_FRAC_BITS;
      hit = 1'b0;
      for (int d = 0; d < 3; d++) begin
         dsum = $signed(prod.nrm[d][0]) + $signed(prod.nrm[d][1])
              + $signed(prod.nrm[d][2]);
         dmag = dsum[DOT_W-1] ? DOT_W'(-dsum) : DOT_W'(dsum);
         // cosine clamped to one before the test
         if (dmag > DOT_ONE) begin
            dmag = DOT_ONE;
         end
         if (dmag > lim) begin
            hit = 1'b1;
         end
      end
   end

   assign point_class    = cls;
   assign normal_aligned = hit && (cls == CLASS_INLIER);

endmodule
